FILE: rtl/rhf_pkg.sv
// ----------------------------------------------------------------------------
// rhf_pkg: shared types and constants of the ripple height field block
// Command codes, register indices, neighbor weights, saturating helper.
// ----------------------------------------------------------------------------
package rhf_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_DROP    = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_DROP  = 2'd0;
    localparam logic [1:0] REG_DAMP  = 2'd1;
    localparam logic [1:0] REG_SPEED = 2'd2;

    localparam logic signed [15:0] W_EDGE = 16'sd10879;
    localparam logic signed [15:0] W_DIAG = 16'sd5439;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        begin
            hi = 36'sh07FFFFFFF;
            lo = -36'sh080000000;
            if (v > hi)
                sat32 = 32'sh7FFFFFFF;
            else if (v < lo)
                sat32 = 32'sh80000000;
            else
                sat32 = v[31:0];
        end
    endfunction

endpackage

FILE: rtl/rhf_grid_mem.sv
// ----------------------------------------------------------------------------
// rhf_grid_mem: one-port-write, one-port-read synchronous memory
// Read data registered.
// ----------------------------------------------------------------------------
module rhf_grid_mem #(
    parameter int AW = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [31:0]       wdata,
    input  logic [AW-1:0]     raddr,
    output logic [31:0]       rdata
);
    logic [31:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/ripple_height_field_step.sv
// ----------------------------------------------------------------------------
// ripple_height_field_step: ripple height field sequencer
// Heights and velocities of a GRID_SIZE x GRID_SIZE grid in two memories,
// updated by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  s_axis   in   tdata = cmd, cell_x, cell_y ; one command
//  m_axis   out  tdata = height, status     ; one result per command
//  cfg      in   we/index/data               ; register writes, idle only
//
// Advance is a border sweep over all address slots (N*N for a power-of-two N),
// a per-slot scan that reads the neighbors of each of the (N-3)^2 interior
// cells and then does its math, and a height sweep.
// New velocities go straight back to the velocity memory (each cell reads only
// its own); interior heights change only in the last sweep, so neighbors read old heights.
// Reset clears control only; the grid is cleared by a sweep after reset,
// during which s_axis_tready is low. Output is a register; the next command
// is taken only once the result beat has been taken.
// ----------------------------------------------------------------------------
module ripple_height_field_step
    import rhf_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [1:0] cmd, [7:2] cell_x, [13:8] cell_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] height, [32] status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int CW = $clog2(GRID_SIZE);
    localparam int AW = 2 * CW;
    // every address slot is visited; slots past the grid count as border
    localparam logic [AW:0] CELLS = {1'b1, {AW{1'b0}}};

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_RD, ST_DROP, ST_BORD, ST_NB, ST_VUP, ST_HUP, ST_OUT
    } state_t;

    state_t state_reg;
    logic signed [31:0] strength_reg;
    logic [16:0] damp_reg, speed_reg;
    logic [AW:0] idx_reg;
    logic [3:0] k_reg;
    logic [CW-1:0] cx_reg, cy_reg;
    logic signed [35:0] e_reg, d_reg;
    logic signed [31:0] hc_reg, vc_reg;
    logic [31:0] out_h_reg;
    logic out_s_reg, out_v_reg;
    logic signed [35:0] lap_reg, damped_reg;
    logic [1:0] ph_reg;

    // memories
    logic h_we, v_we;
    logic [AW-1:0] h_wa, v_wa, h_ra, v_ra;
    logic [31:0] h_wd, v_wd, h_rd, v_rd;

    rhf_grid_mem #(.AW(AW)) u_h (.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd),
        .raddr(h_ra), .rdata(h_rd));
    rhf_grid_mem #(.AW(AW)) u_v (.clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd),
        .raddr(v_ra), .rdata(v_rd));

    logic [1:0] in_cmd;
    logic [5:0] in_x, in_y;
    assign in_cmd = s_axis_tdata[1:0];
    assign in_x   = s_axis_tdata[7:2];
    assign in_y   = s_axis_tdata[13:8];

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {7'd0, out_s_reg, out_h_reg};

    // cell coordinates of idx
    logic [CW-1:0] ix, iy;
    assign ix = idx_reg[CW-1:0];
    assign iy = idx_reg[AW-1:CW];
    logic border;
    assign border = (ix <= CW'(1)) || (ix == CW'(GRID_SIZE - 1)) ||
                    (iy <= CW'(1)) || (iy == CW'(GRID_SIZE - 1)) ||
                    ({1'b0, ix} >= (CW + 1)'(GRID_SIZE - 1)) ||
                    ({1'b0, iy} >= (CW + 1)'(GRID_SIZE - 1));

    // neighbor offsets for k: 0..8 = 3x3 row by row, k_reg 9 = no offset (centre)
    logic signed [2:0] dx, dy;
    always_comb
    begin
        case (k_reg)
            4'd0:    begin dx = -3'sd1; dy = -3'sd1; end
            4'd1:    begin dx =  3'sd0; dy = -3'sd1; end
            4'd2:    begin dx =  3'sd1; dy = -3'sd1; end
            4'd3:    begin dx = -3'sd1; dy =  3'sd0; end
            4'd5:    begin dx =  3'sd1; dy =  3'sd0; end
            4'd6:    begin dx = -3'sd1; dy =  3'sd1; end
            4'd7:    begin dx =  3'sd0; dy =  3'sd1; end
            4'd8:    begin dx =  3'sd1; dy =  3'sd1; end
            default: begin dx =  3'sd0; dy =  3'sd0; end
        endcase
    end
    logic [CW-1:0] nx, ny;
    assign nx = CW'($signed({1'b0, cx_reg}) + dx);
    assign ny = CW'($signed({1'b0, cy_reg}) + dy);
    logic [AW-1:0] naddr;
    assign naddr = {ny, nx};

    logic [3:0] k_d_reg;
    logic [AW-1:0] a_d_reg;
    logic rd_v_reg;

    // drop impulse of the pending kick
    logic signed [31:0] imp;
    always_comb
    begin
        if (k_d_reg == 4'd4)
            imp = strength_reg >>> 2;
        else if (k_d_reg == 4'd1 || k_d_reg == 4'd3 || k_d_reg == 4'd5 || k_d_reg == 4'd7)
            imp = strength_reg >>> 3;
        else
            imp = strength_reg >>> 4;
    end

    logic signed [31:0] hsum;
    logic signed [63:0] lap_prod, dmp_prod, trm_prod;
    logic signed [35:0] diff;
    always_comb
    begin
        lap_prod = 64'(e_reg) * 64'(W_EDGE) + 64'(d_reg) * 64'(W_DIAG);
        dmp_prod = 64'(vc_reg) * 64'(signed'({1'b0, damp_reg}));
        diff = lap_reg - 36'(hc_reg);
        trm_prod = 64'(diff) * 64'(signed'({1'b0, speed_reg}));
        hsum = sat32(36'(signed'(h_rd)) + 36'(signed'(v_rd)));
    end

    always_comb
    begin
        h_we = 1'b0; v_we = 1'b0;
        h_wa = idx_reg[AW-1:0]; v_wa = idx_reg[AW-1:0];
        h_wd = '0; v_wd = '0;
        h_ra = idx_reg[AW-1:0]; v_ra = idx_reg[AW-1:0];
        case (state_reg)
            ST_CLR, ST_BORD:
            begin
                if (state_reg == ST_CLR || border)
                begin
                    h_we = 1'b1; v_we = 1'b1;
                end
            end
            ST_IDLE:
            begin
                h_ra = {CW'(in_y), CW'(in_x)};
            end
            ST_DROP:
            begin
                v_ra = naddr;
                v_wa = a_d_reg;
                v_we = rd_v_reg;
                v_wd = sat32(36'(signed'(v_rd)) - 36'(imp));
            end
            ST_NB:
            begin
                h_ra = naddr;
                v_ra = {cy_reg, cx_reg};
            end
            ST_VUP:
            begin
                v_we = (ph_reg == 2'd2);
                v_wa = {cy_reg, cx_reg};
                v_wd = sat32(damped_reg + 36'(trm_prod >>> 16));
            end
            ST_HUP:
            begin
                h_wa = a_d_reg;
                h_we = rd_v_reg;
                h_wd = hsum;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            idx_reg <= '0;
            k_reg <= '0;
            ph_reg <= '0;
            rd_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
            strength_reg <= 32'sd65536;
            damp_reg <= 17'd64225;
            speed_reg <= 17'd16384;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DROP:  strength_reg <= cfg_data;
                    REG_DAMP:  damp_reg <= cfg_data[16:0];
                    REG_SPEED: speed_reg <= cfg_data[16:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                out_v_reg <= 1'b0;
            case (state_reg)
                ST_CLR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == CELLS - 1'b1)
                    begin
                        idx_reg <= '0;
                        state_reg <= (out_v_reg || ph_reg != 2'd0) ? ST_OUT : ST_IDLE;
                        out_h_reg <= '0; out_s_reg <= 1'b0;
                        ph_reg <= '0;
                    end
                end
                ST_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        out_h_reg <= '0;
                        out_s_reg <= 1'b0;
                        cx_reg <= CW'(in_x);
                        cy_reg <= CW'(in_y);
                        idx_reg <= '0;
                        k_reg <= '0;
                        rd_v_reg <= 1'b0;
                        case (in_cmd)
                            CMD_CLEAR:
                            begin
                                state_reg <= ST_CLR;
                                ph_reg <= 2'd1;
                            end
                            CMD_DROP:
                            begin
                                if (in_x < 6'd1 || 32'(in_x) > GRID_SIZE - 2 ||
                                    in_y < 6'd1 || 32'(in_y) > GRID_SIZE - 2)
                                begin
                                    out_s_reg <= 1'b1;
                                    state_reg <= ST_OUT;
                                end
                                else
                                    state_reg <= ST_DROP;
                            end
                            CMD_ADVANCE: state_reg <= ST_BORD;
                            default:
                            begin
                                if (32'(in_x) < GRID_SIZE && 32'(in_y) < GRID_SIZE)
                                    state_reg <= ST_RD;
                                else
                                    state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_RD:
                begin
                    out_h_reg <= h_rd;
                    state_reg <= ST_OUT;
                end
                ST_DROP:
                begin
                    // read at k, write back in the next cycle (distinct cells)
                    a_d_reg <= naddr;
                    k_d_reg <= k_reg;
                    rd_v_reg <= (k_reg < 4'd9);
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 4'd9)
                        state_reg <= ST_OUT;
                end
                ST_BORD:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == CELLS - 1'b1)
                    begin
                        idx_reg <= '0;
                        cx_reg <= '0; cy_reg <= '0;
                        state_reg <= ST_VUP;
                        ph_reg <= 2'd3;
                    end
                end
                ST_NB:
                begin
                    // neighbor k is addressed while k_reg is k; its registered height is used when k_reg is k+1
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 4'd0)
                    begin
                        e_reg <= '0; d_reg <= '0;
                    end
                    else
                    begin
                        if (k_reg == 4'd5)
                            hc_reg <= h_rd;
                        else if (k_reg == 4'd2 || k_reg == 4'd4 || k_reg == 4'd6 ||
                                 k_reg == 4'd8)
                            e_reg <= e_reg + 36'(signed'(h_rd));
                        else
                            d_reg <= d_reg + 36'(signed'(h_rd));
                    end
                    if (k_reg == 4'd1)
                        vc_reg <= v_rd;
                    if (k_reg == 4'd9)
                    begin
                        state_reg <= ST_VUP;
                        ph_reg <= 2'd0;
                    end
                end
                ST_VUP:
                begin
                    // ph 3: pick next cell; 0: lap/damp; 1: term; 2: write
                    case (ph_reg)
                        2'd0:
                        begin
                            lap_reg <= 36'(lap_prod >>> 16);
                            damped_reg <= 36'(dmp_prod >>> 16);
                            ph_reg <= 2'd1;
                        end
                        2'd1: ph_reg <= 2'd2;
                        2'd2: ph_reg <= 2'd3;
                        default:
                        begin
                            if (idx_reg == CELLS)
                            begin
                                idx_reg <= '0;
                                rd_v_reg <= 1'b0;
                                state_reg <= ST_HUP;
                            end
                            else
                            begin
                                cx_reg <= ix; cy_reg <= iy;
                                idx_reg <= idx_reg + 1'b1;
                                if (!border)
                                begin
                                    k_reg <= '0;
                                    state_reg <= ST_NB;
                                end
                            end
                        end
                    endcase
                end
                ST_HUP:
                begin
                    a_d_reg <= idx_reg[AW-1:0];
                    rd_v_reg <= (idx_reg != CELLS);
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == CELLS)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_v_reg)
                    begin
                        out_v_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: tb/ripple_height_field_checker.sv
// ----------------------------------------------------------------------------
// ripple_height_field_checker: scoreboard of the ripple height field block
// Watches the command and result streams, keeps its own copy of the grid and
// the registers, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module ripple_height_field_checker
    import rhf_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int CELLS = GRID_SIZE * GRID_SIZE;

    typedef struct packed {
        logic        status;
        logic [31:0] height;
    } answer_t;

    logic signed [31:0] grid_h [CELLS];
    logic signed [31:0] grid_v [CELLS];
    logic signed [31:0] strength;
    logic [16:0]        damping;
    logic [16:0]        speed;
    answer_t            answers [$];

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic bit on_border(input int x, input int y);
        return x <= 1 || y <= 1 || x >= GRID_SIZE - 1 || y >= GRID_SIZE - 1;
    endfunction

    task automatic kick(input int idx, input logic signed [63:0] imp);
        grid_v[idx] = clamp32(64'(grid_v[idx]) - imp);
    endtask

    task automatic advance_frame();
        logic signed [31:0] nv [CELLS];
        logic signed [63:0] e, d, lap, damped, term;
        int c;
        for (int y = 0; y < GRID_SIZE; y++)
            for (int x = 0; x < GRID_SIZE; x++)
                if (on_border(x, y))
                begin
                    grid_h[x + y * GRID_SIZE] = 0;
                    grid_v[x + y * GRID_SIZE] = 0;
                end
        nv = grid_v;
        for (int y = 2; y < GRID_SIZE - 1; y++)
            for (int x = 2; x < GRID_SIZE - 1; x++)
            begin
                c = x + y * GRID_SIZE;
                e = 64'(grid_h[c - 1]) + grid_h[c + 1] + grid_h[c - GRID_SIZE]
                    + grid_h[c + GRID_SIZE];
                d = 64'(grid_h[c - GRID_SIZE - 1]) + grid_h[c - GRID_SIZE + 1]
                    + grid_h[c + GRID_SIZE - 1] + grid_h[c + GRID_SIZE + 1];
                lap = (e * 10879 + d * 5439) >>> 16;
                damped = (64'(signed'({1'b0, damping})) * grid_v[c]) >>> 16;
                term = ((lap - grid_h[c]) * 64'(signed'({1'b0, speed}))) >>> 16;
                nv[c] = clamp32(damped + term);
            end
        grid_v = nv;
        for (int i = 0; i < CELLS; i++)
            grid_h[i] = clamp32(64'(grid_h[i]) + grid_v[i]);
    endtask

    // predict the answer to one command beat and update the grid copy
    task automatic apply_command(input logic [15:0] beat);
        cmd_t               cmd;
        int                 x, y, c;
        answer_t            a;
        logic signed [63:0] s;
        cmd = cmd_t'(beat[1:0]);
        x = beat[7:2];
        y = beat[13:8];
        a = '0;
        s = 64'(strength);
        case (cmd)
            CMD_CLEAR:
            begin
                foreach (grid_h[i])
                begin
                    grid_h[i] = 0;
                    grid_v[i] = 0;
                end
            end
            CMD_DROP:
            begin
                if (x < 1 || x > GRID_SIZE - 2 || y < 1 || y > GRID_SIZE - 2)
                    a.status = 1'b1;
                else
                begin
                    c = x + y * GRID_SIZE;
                    kick(c, s >>> 2);
                    kick(c - 1, s >>> 3);
                    kick(c + 1, s >>> 3);
                    kick(c - GRID_SIZE, s >>> 3);
                    kick(c + GRID_SIZE, s >>> 3);
                    kick(c - GRID_SIZE - 1, s >>> 4);
                    kick(c - GRID_SIZE + 1, s >>> 4);
                    kick(c + GRID_SIZE - 1, s >>> 4);
                    kick(c + GRID_SIZE + 1, s >>> 4);
                end
            end
            CMD_ADVANCE: advance_frame();
            default:
                if (x < GRID_SIZE && y < GRID_SIZE)
                    a.height = grid_h[x + y * GRID_SIZE];
        endcase
        answers.push_back(a);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t exp_a;
        if (!rst_n)
        begin
            foreach (grid_h[i])
            begin
                grid_h[i] = 0;
                grid_v[i] = 0;
            end
            strength = 32'sd65536;
            damping = 17'd64225;
            speed = 17'd16384;
            answers.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    REG_DROP:  strength = cfg_data;
                    REG_DAMP:  damping = cfg_data[16:0];
                    REG_SPEED: speed = cfg_data[16:0];
                    default: ;
                endcase
            // result beat is checked before the command beat of the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (answers.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result beat %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_a = answers.pop_front();
                    if (m_axis_tdata[31:0] !== exp_a.height
                        || m_axis_tdata[32] !== exp_a.status)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: height exp %h got %h, status exp %b got %b",
                                     exp_a.height, m_axis_tdata[31:0],
                                     exp_a.status, m_axis_tdata[32]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_command(s_axis_tdata);
            pending <= answers.size();
        end
    end

endmodule

FILE: tb/tb_ripple_height_field_step.sv
// ----------------------------------------------------------------------------
// tb_ripple_height_field_step: testbench of the ripple height field block
// Directed commands, then random drops/advances/reads/clears under several register
// settings, with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_ripple_height_field_step
    import rhf_pkg::*;
;

    localparam int GRID_SIZE = 64;
    localparam int IDLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [1:0] cmd, [7:2] cell_x, [13:8] cell_y
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // [31:0] height, [32] status
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_off;        // long receiver stall requested

    ripple_height_field_step #(.GRID_SIZE(GRID_SIZE)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ripple_height_field_checker #(.GRID_SIZE(GRID_SIZE)) i_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // receiver: random ready, plus one long counted stall on request
    initial
    begin
        int n;
        bit stalled;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off && !stalled)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                stalled = 1'b1;
            end
            n = gap_len();
            m_axis_tready <= (n == 0);
            repeat (n > 0 ? n : 1) @(posedge clk);
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // watchdog on accepted beats
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // valid stays high after the beat is taken until the next send or drain
    task automatic send(input cmd_t cmd, input int x, input int y);
        int n;
        n = gap_len();
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, 6'(y), 6'(x), cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // random phase: mostly drops and reads inside the grid, rare advances
    task automatic random_phase(input int count);
        int r, x, y;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            x = $urandom_range(0, 63);
            y = $urandom_range(0, 63);
            if (r < 10)
                send(CMD_ADVANCE, x, y);
            else if (r < 45)
                send(CMD_DROP, $urandom_range(0, 9) == 0 ? x : $urandom_range(1, 62),
                     $urandom_range(0, 9) == 0 ? y : $urandom_range(1, 62));
            else if (r < 98)
                send(CMD_READ, x, y);
            else
                send(CMD_CLEAR, x, y);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: drops at the edges of the legal range and outside it, then reads, an advance and a clear
        send(CMD_DROP, 1, 1);
        send(CMD_DROP, 62, 62);
        send(CMD_DROP, 0, 5);
        send(CMD_DROP, 5, 63);
        send(CMD_DROP, 63, 0);
        send(CMD_DROP, 30, 30);
        send(CMD_READ, 30, 30);
        send(CMD_READ, 1, 1);
        send(CMD_ADVANCE, 0, 0);
        send(CMD_READ, 1, 1);     // border zeroed by advance
        send(CMD_READ, 31, 30);
        send(CMD_READ, 63, 63);
        send(CMD_CLEAR, 63, 63);
        send(CMD_READ, 30, 30);
        // long output stall while commands keep coming
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++)
            send(CMD_READ, i * 10, 63 - i * 10);
        drain();

        // extreme settings: big negative strength, full damping and speed
        write_reg(REG_DROP, 32'h80000000);
        write_reg(REG_DAMP, 32'h00010000);
        write_reg(REG_SPEED, 32'h00010000);
        write_reg(2'd3, 32'hFFFFFFFF);
        for (int i = 0; i < 4; i++)
            send(CMD_DROP, 20, 20);
        send(CMD_ADVANCE, 0, 0);
        send(CMD_READ, 20, 20);
        random_phase(25);
        drain();

        write_reg(REG_DROP, 32'h7FFFFFFF);
        write_reg(REG_DAMP, 32'h0);
        write_reg(REG_SPEED, 32'h0);
        send(CMD_CLEAR, 0, 0);
        for (int i = 0; i < 4; i++)
            send(CMD_DROP, 40, 40);
        random_phase(25);
        drain();

        write_reg(REG_DROP, $urandom);
        write_reg(REG_DAMP, $urandom_range(0, 65536));
        write_reg(REG_SPEED, $urandom_range(0, 65536));
        random_phase(35);
        drain();

        write_reg(REG_DROP, 32'd65536);
        write_reg(REG_DAMP, 32'd64225);
        write_reg(REG_SPEED, 32'd16384);
        random_phase(35);
        drain();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
